// ===== src/ntdi_pkg.sv =====
// Shared types, constants and helpers for the note-to-DAC interpolator.
// No dependencies; every other file imports this package.
package ntdi_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;

    localparam logic [15:0] NOTE_OFFSET = 16'(36 << 7);
    localparam logic [12:0] NOTE_SPAN   = 13'(48 << 7);
    localparam logic [15:0] RESET_STEP  = 16'd500;
    localparam logic [7:0]  THIRD_OF_256 = 8'd85;

    // floor(x / 3) by reciprocal multiply
    localparam logic [9:0]  RECIP3_SEG  = 10'd11;   // x < 32, shift 5
    localparam logic [9:0]  RECIP3_REM  = 10'd683;  // x < 2048, shift 11

    typedef enum logic {
        OP_CONVERT = 1'b0,
        OP_WRITE   = 1'b1
    } ntdi_op_t;

    typedef struct packed {
        logic        en;
        logic [3:0]  index;
        logic [15:0] value;
    } ntdi_wr_t;

    // Code read from a table entry that has not been written since reset.
    function automatic logic [15:0] ramp_code(input logic [3:0] idx);
        ramp_code = 16'({12'd0, idx} * RESET_STEP);
    endfunction

endpackage

// ===== src/ntdi_seg.sv =====
// Pitch offset, clamp and split into table segment and 16-bit fraction.
// Depends on ntdi_pkg.
module ntdi_seg (
    input  logic        clk,
    input  logic        load,
    input  logic [15:0] note,
    output logic [3:0]  lo_addr,
    output logic [3:0]  hi_addr,
    output logic [15:0] frac_reg
);
    import ntdi_pkg::*;

    logic [15:0] shifted;
    logic [12:0] pitch;
    logic [9:0]  seg_prod;
    logic [3:0]  seg;
    logic [12:0] seg_base;
    logic [9:0]  rem;
    logic [19:0] rem_prod;
    logic [7:0]  third;
    logic [9:0]  third_x3;
    logic [1:0]  leftover;
    logic [15:0] frac_next;

    always_comb
    begin
        shifted = note - NOTE_OFFSET;
        if (shifted[15])
            pitch = '0;
        else if (shifted[14:0] > 15'(NOTE_SPAN))
            pitch = NOTE_SPAN;
        else
            pitch = shifted[12:0];

        // segment = pitch / 768 = (pitch >> 8) / 3
        seg_prod = {5'd0, pitch[12:8]} * RECIP3_SEG;
        seg      = seg_prod[8:5];
        seg_base = {1'b0, seg, 8'd0} + {seg, 9'd0};
        rem      = 10'(pitch - seg_base);

        // floor(rem * 256 / 3) = 256 * (rem / 3) + 85 * (rem % 3)
        rem_prod  = {10'd0, rem} * {10'd0, RECIP3_REM};
        third     = rem_prod[18:11];
        third_x3  = {1'b0, third, 1'b0} + {2'b0, third};
        leftover  = 2'(rem - third_x3);
        frac_next = {third, 8'd0} + 16'({6'd0, leftover} * THIRD_OF_256);
    end

    assign lo_addr = seg;
    assign hi_addr = seg + 4'd1;

    always_ff @(posedge clk)
    begin
        if (load)
            frac_reg <= frac_next;
    end

endmodule

// ===== src/ntdi_table.sv =====
// Calibration table: one write port, two registered read ports.
// Unwritten entries read as the reset ramp. Depends on ntdi_pkg.
module ntdi_table #(
    parameter int TABLE_DEPTH = ntdi_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ntdi_pkg::ntdi_wr_t wr,
    input  logic             rd_en,
    input  logic [3:0]       lo_addr,
    input  logic [3:0]       hi_addr,
    output logic [15:0]      lo_data,
    output logic [15:0]      hi_data
);
    import ntdi_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [15:0]            mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] written_reg;
    logic [AW-1:0]          wr_idx;
    logic [AW-1:0]          lo_idx;
    logic [AW-1:0]          hi_idx;
    logic [15:0]            lo_mem_reg;
    logic [15:0]            hi_mem_reg;
    logic                   lo_ok_reg;
    logic                   hi_ok_reg;
    logic [3:0]             lo_addr_reg;
    logic [3:0]             hi_addr_reg;

    assign wr_idx = wr.index[AW-1:0];
    assign lo_idx = lo_addr[AW-1:0];
    assign hi_idx = hi_addr[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr_idx] <= wr.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            written_reg <= '0;
        else if (wr.en)
            written_reg[wr_idx] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            lo_mem_reg  <= mem[lo_idx];
            hi_mem_reg  <= mem[hi_idx];
            lo_ok_reg   <= written_reg[lo_idx];
            hi_ok_reg   <= written_reg[hi_idx];
            lo_addr_reg <= lo_addr;
            hi_addr_reg <= hi_addr;
        end
    end

    assign lo_data = lo_ok_reg ? lo_mem_reg : ramp_code(lo_addr_reg);
    assign hi_data = hi_ok_reg ? hi_mem_reg : ramp_code(hi_addr_reg);

endmodule

// ===== src/ntdi_interp.sv =====
// Interpolation: multiply stage then add into the result register.
// Depends on ntdi_pkg.
module ntdi_interp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] lo,
    input  logic [15:0] hi,
    input  logic [15:0] frac,
    output logic        code_valid,
    input  logic        code_stall,
    output logic [15:0] dac_value
);
    import ntdi_pkg::*;

    logic signed [16:0] delta;
    logic signed [33:0] prod;
    logic               mul_valid_reg;
    logic [15:0]        mul_lo_reg;
    logic [15:0]        mul_step_reg;
    logic               out_valid_reg;
    logic [15:0]        out_code_reg;
    logic               out_ready;
    logic               mul_ready;

    // product taken modulo 2^32, upper half kept
    assign delta = $signed({1'b0, hi}) - $signed({1'b0, lo});
    assign prod  = $signed({{17{delta[16]}}, delta}) * $signed({18'd0, frac});

    assign out_ready = !out_valid_reg || !code_stall;
    assign mul_ready = !mul_valid_reg || out_ready;
    assign in_ready  = mul_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_ready)
                mul_valid_reg <= in_valid;
            if (out_ready)
                out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_ready && in_valid)
        begin
            mul_lo_reg   <= lo;
            mul_step_reg <= prod[31:16];
        end
        if (out_ready && mul_valid_reg)
            out_code_reg <= mul_lo_reg + mul_step_reg;
    end

    assign code_valid = out_valid_reg;
    assign dac_value  = out_code_reg;

endmodule

// ===== src/note_to_dac_interpolator_core.sv =====
// Note-to-DAC interpolator: pitch in 1/128 semitones to a DAC code by linear
// interpolation in a writable calibration table. One transfer is taken every clock
// cycle unless cmd_stall is high; a conversion reaches the result register through
// the table read, multiply and add stages behind the input register, and a table write
// takes effect for the next item and yields no result. A held result backs up through
// the stages to cmd_stall in the same cycle; a write in the input register never
// stalls and completes while results are held. Unwritten table entries read as 500
// times their index. Depends on ntdi_pkg, ntdi_seg, ntdi_table and ntdi_interp.
module note_to_dac_interpolator_core #(
    parameter int TABLE_DEPTH = ntdi_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic        op,
    input  logic [15:0] note,
    input  logic [3:0]  entry_index,
    input  logic [15:0] entry_value,
    output logic        code_valid,
    input  logic        code_stall,
    output logic [15:0] dac_value
);
    import ntdi_pkg::*;

    logic        in_valid_reg;
    logic        op_reg;
    logic [15:0] note_reg;
    logic [3:0]  index_reg;
    logic [15:0] value_reg;
    logic        rd_valid_reg;
    logic        rd_ready;
    logic        interp_ready;
    logic [3:0]  lo_addr;
    logic [3:0]  hi_addr;
    logic [15:0] frac;
    logic [15:0] lo_data;
    logic [15:0] hi_data;
    ntdi_wr_t    wr;

    assign rd_ready  = !rd_valid_reg || interp_ready;
    assign cmd_stall = in_valid_reg && (op_reg == OP_CONVERT) && !rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (!cmd_stall)
                in_valid_reg <= cmd_valid;
            if (rd_ready)
                rd_valid_reg <= in_valid_reg && (op_reg == OP_CONVERT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            op_reg    <= op;
            note_reg  <= note;
            index_reg <= entry_index;
            value_reg <= entry_value;
        end
    end

    always_comb
    begin
        wr.en    = in_valid_reg && (op_reg == OP_WRITE) && (int'(index_reg) < TABLE_DEPTH);
        wr.index = index_reg;
        wr.value = value_reg;
    end

    ntdi_seg u_seg (
        .clk      (clk),
        .load     (rd_ready),
        .note     (note_reg),
        .lo_addr  (lo_addr),
        .hi_addr  (hi_addr),
        .frac_reg (frac)
    );

    ntdi_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_en   (rd_ready),
        .lo_addr (lo_addr),
        .hi_addr (hi_addr),
        .lo_data (lo_data),
        .hi_data (hi_data)
    );

    ntdi_interp u_interp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rd_valid_reg),
        .in_ready   (interp_ready),
        .lo         (lo_data),
        .hi         (hi_data),
        .frac       (frac),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .dac_value  (dac_value)
    );

endmodule

// ===== src/ntdi_checker.sv =====
// Port-level checks for note_to_dac_interpolator_core, bound to the top level.
// Depends on ntdi_pkg.
module ntdi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_stall,
    input logic        op,
    input logic        code_valid,
    input logic        code_stall,
    input logic [15:0] dac_value
);
    import ntdi_pkg::*;

    a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code_stall |=> code_valid)
        else $error("result dropped while stalled");

    a_hold_code : assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code_stall |=> $stable(dac_value))
        else $error("result changed while stalled");

    a_no_stall_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !code_valid |-> !cmd_stall)
        else $error("input stalled with empty result register");

    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && (op == OP_CONVERT) && !code_stall) ##1 !code_stall
            ##1 !code_stall ##1 !code_stall |=> code_valid)
        else $error("conversion did not reach result register");

endmodule

bind note_to_dac_interpolator_core ntdi_checker u_ntdi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .op         (op),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .dac_value  (dac_value)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for note_to_dac_interpolator_core: pitch conversions
// and calibration table writes are checked against an in-bench interpolation model.
// Depends on the core RTL and ntdi_pkg only.
module tb;
    import ntdi_pkg::*;

    typedef struct packed {
        ntdi_op_t    kind;
        logic [15:0] pitch;
        logic [3:0]  slot;
        logic [15:0] code;
        logic        drain_first;
    } cal_cmd_t;

    localparam logic [15:0] PITCH_OFFSET  = 16'd4608;
    localparam logic [15:0] PITCH_SPAN    = 16'd6144;
    localparam int          SEG_WIDTH     = 768;
    localparam int          RAMP_STEP     = 500;
    localparam int          N_RANDOM      = 1725;
    localparam int          DRAIN_AT      = 1000;
    localparam int          TAIL_ITEMS    = 150;
    localparam int          HOLD_AFTER    = 250;
    localparam int          LONG_HOLD     = 400;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          CYCLE_LIMIT   = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    logic        op = 1'b0;
    logic [15:0] note = '0;
    logic [3:0]  entry_index = '0;
    logic [15:0] entry_value = '0;
    logic        code_valid;
    logic        code_stall = 1'b0;
    logic [15:0] dac_value;

    cal_cmd_t    pending_cmds[$];
    logic [15:0] codes_due[$];
    logic [15:0] cal_table[16];

    cal_cmd_t    cur_cmd;
    logic        offering;
    logic        stall_next;
    bit          quiet_tail = 1'b0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          send_idle_rate = 6;
    int          recv_idle_rate = 6;
    int          conversions_done = 0;
    int          writes_done = 0;
    int          results_checked = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    logic [15:0] want_code;

    note_to_dac_interpolator_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .op          (op),
        .note        (note),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .code_valid  (code_valid),
        .code_stall  (code_stall),
        .dac_value   (dac_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clamped pitch split into segment and 16-bit fraction, then interpolated.
    function automatic logic [15:0] interp_dac_value(input logic [15:0] pitch);
        logic [15:0] shifted;
        logic [15:0] pos;
        logic [3:0]  seg;
        logic [31:0] frac;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] delta;
        logic [31:0] prod;
        logic [31:0] sum;
        shifted = pitch - PITCH_OFFSET;
        if (shifted[15])
            pos = '0;
        else if (shifted > PITCH_SPAN)
            pos = PITCH_SPAN;
        else
            pos = shifted;
        seg   = 4'(32'(pos) / SEG_WIDTH);
        frac  = ((32'(pos) % SEG_WIDTH) * 32'd256) / 32'd3;
        lo    = 32'(cal_table[seg]);
        hi    = 32'(cal_table[seg + 4'd1]);
        delta = hi - lo;
        prod  = delta * frac;
        sum   = lo + (prod >> 16);
        return sum[15:0];
    endfunction

    function automatic int pick_idle_rate();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 24;
            2: return 6;
            default: return 2;
        endcase
    endfunction

    task automatic add_convert(input logic [15:0] pitch, input logic drain);
        cal_cmd_t c;
        c = '{kind: OP_CONVERT, pitch: pitch, slot: 4'($urandom),
              code: 16'($urandom), drain_first: drain};
        pending_cmds.push_back(c);
    endtask

    task automatic add_write(input logic [3:0] slot, input logic [15:0] code, input logic drain);
        cal_cmd_t c;
        c = '{kind: OP_WRITE, pitch: 16'($urandom), slot: slot, code: code,
              drain_first: drain};
        pending_cmds.push_back(c);
    endtask

    // Driver: predicts each accepted transfer, then presents the next pending item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            for (int i = 0; i < 16; i++)
                cal_table[i] = 16'(i * RAMP_STEP);
        end
        else
        begin
            offering = cmd_valid;
            quiet_tail = (pending_cmds.size() < TAIL_ITEMS);
            if ($urandom_range(0, 255) == 0)
                send_idle_rate = pick_idle_rate();
            if (cmd_valid && !cmd_stall)
            begin
                if (cur_cmd.kind == OP_WRITE)
                begin
                    cal_table[cur_cmd.slot] = cur_cmd.code;
                    writes_done++;
                end
                else
                begin
                    codes_due.push_back(interp_dac_value(cur_cmd.pitch));
                    conversions_done++;
                end
                offering = 1'b0;
            end
            if (!offering && pending_cmds.size() > 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (!quiet_tail && send_idle_rate != 0 &&
                         $urandom_range(0, send_idle_rate - 1) == 0)
                    send_gap = $urandom_range(0, 17);
                else if (!pending_cmds[0].drain_first || codes_due.size() == 0)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    offering = 1'b1;
                    op <= cur_cmd.kind;
                    note <= cur_cmd.pitch;
                    entry_index <= cur_cmd.slot;
                    entry_value <= cur_cmd.code;
                end
            end
            cmd_valid <= offering;
        end
    end

    // Monitor: checks each result transfer and drives the receiver stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            code_stall <= 1'b0;
        else
        begin
            if ($urandom_range(0, 255) == 0)
                recv_idle_rate = pick_idle_rate();
            if (code_valid && !code_stall)
            begin
                if (codes_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: dac_value expected none, actual %h", $time, dac_value);
                end
                else
                begin
                    want_code = codes_due.pop_front();
                    results_checked++;
                    if (dac_value !== want_code)
                    begin
                        mismatches++;
                        $display("%0t: dac_value expected %h, actual %h",
                                 $time, want_code, dac_value);
                    end
                end
            end
            if (results_checked == HOLD_AFTER && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            stall_next = 1'b0;
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                stall_next = 1'b1;
            end
            else if (!quiet_tail && recv_idle_rate != 0 &&
                     $urandom_range(0, recv_idle_rate - 1) == 0)
            begin
                recv_gap = $urandom_range(0, 17);
                stall_next = 1'b1;
            end
            code_stall <= stall_next;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        // offset wrap, clamp edges, fraction edges at reset table
        add_convert(16'h8000, 1'b0);
        add_convert(16'h7FFF, 1'b0);
        add_convert(16'(-28160), 1'b0);
        add_convert(16'(-28161), 1'b0);
        add_convert(16'd4607, 1'b0);
        add_convert(16'd4608, 1'b0);
        add_convert(16'd4608 + 16'd191, 1'b0);
        add_convert(16'd4608 + 16'd192, 1'b0);
        add_convert(16'd4608 + 16'd193, 1'b0);
        add_convert(16'd4608 + 16'd767, 1'b0);
        add_convert(16'd4608 + 16'd768, 1'b0);
        add_convert(16'd4608 + 16'd6143, 1'b0);
        add_convert(16'd4608 + 16'd6144, 1'b0);
        add_convert(16'd4608 + 16'd6145, 1'b0);
        add_convert(16'd0, 1'b0);
        // descending segment, then full-scale steps around the top entry
        add_write(4'd0, 16'hFFFF, 1'b0);
        add_write(4'd1, 16'h0000, 1'b0);
        add_convert(16'd4608 + 16'd384, 1'b0);
        add_write(4'd8, 16'hFFFF, 1'b0);
        add_write(4'd9, 16'h0000, 1'b0);
        add_write(4'd7, 16'h0000, 1'b0);
        add_convert(16'd4608 + 16'd6144, 1'b0);
        add_convert(16'd4608 + 16'd6143, 1'b0);
        add_write(4'd15, 16'hFFFF, 1'b0);
        add_write(4'd3, 16'h0000, 1'b0);

        for (int k = 0; k < N_RANDOM; k++)
        begin
            logic [15:0] pitch;
            logic [15:0] code;
            logic        drain;
            drain = (k == DRAIN_AT);
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 5))
                    0: code = 16'h0000;
                    1: code = 16'hFFFF;
                    default: code = 16'($urandom);
                endcase
                add_write(4'($urandom), code, drain);
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0, 1: pitch = 16'($urandom);
                    2:
                    begin
                        case ($urandom_range(0, 3))
                            0: pitch = 16'd4608;
                            1: pitch = 16'd4608 + PITCH_SPAN;
                            2: pitch = 16'(-28160);
                            default: pitch = 16'd4608 + 16'(SEG_WIDTH * $urandom_range(0, 8));
                        endcase
                        pitch = pitch + 16'($urandom_range(0, 6)) - 16'd3;
                    end
                    default: pitch = PITCH_OFFSET + 16'($urandom_range(0, 6144));
                endcase
                add_convert(pitch, drain);
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || cmd_valid)
            @(posedge clk);
        while (codes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d conversions and %0d table writes, %0d results checked",
                 conversions_done, writes_done, results_checked);
        $display("%0d mismatches in %0d cycles", mismatches, cycle_count);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== note_to_dac_interpolator_core.f =====
src/ntdi_pkg.sv
src/ntdi_seg.sv
src/ntdi_table.sv
src/ntdi_interp.sv
src/note_to_dac_interpolator_core.sv
src/ntdi_checker.sv
tb/sv/tb.sv
